@@ src/lpfd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed framer/deframer.
// No dependencies; every other file imports this package.
package lpfd_pkg;

    localparam int STORE_BYTES = 16384;
    localparam int CNT_W       = $clog2(STORE_BYTES + 1);
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CFG_W       = 15;
    localparam int PEND_W      = 15;
    localparam int HDR_BYTES   = 4;
    localparam int MIN_FRAME   = 5;
    localparam int MAX_RESET   = 16384;

    localparam logic [CNT_W-1:0] HDR_CNT   = CNT_W'(HDR_BYTES);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_RESET);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FLUSH = 2'd1,
        OP_READ  = 2'd2,
        OP_RECV  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]        data;
        logic              valid;
        logic              last;
        status_t           status;
        logic [PEND_W-1:0] pending;
        logic              use_mem;
    } res_t;

endpackage

@@ src/lpfd_ifs.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces (valid/ready plus payload).
// Depends on lpfd_pkg.
interface lpfd_item_if
    import lpfd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_in;

    modport source (output valid, output opcode, output data_in, input ready);
    modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface lpfd_result_if
    import lpfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [7:0]        data_out;
    logic              data_valid;
    logic              frame_last;
    logic [1:0]        status;
    logic [PEND_W-1:0] pending;

    modport source (output valid, output data_out, output data_valid, output frame_last,
                    output status, output pending, input ready);
    modport sink   (input valid, input data_out, input data_valid, input frame_last,
                    input status, input pending, output ready);
endinterface

@@ src/lpfd_tx.sv @@
`timescale 1ns / 1ps
// Transmit path: frame buffer memory, fill/drain counters and header bytes.
// Depends on lpfd_pkg.
module lpfd_tx
    import lpfd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  op_t              opcode,
    input  logic [7:0]       data_in,
    input  logic [CFG_W-1:0] frame_limit,
    output res_t             res,
    output logic [7:0]       mem_rdata
);

    logic [7:0]       mem [STORE_BYTES];
    logic [7:0]       mem_rdata_reg;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] frame_len_reg, frame_len_next;
    logic [CNT_W-1:0] read_pos_reg, read_pos_next;
    logic             draining_reg, draining_next;

    logic [CNT_W-1:0] eff_max;
    logic [CNT_W-1:0] fill_w;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] pos_inc;
    logic [31:0]      hdr_word;
    logic             wr_en;
    logic             rd_en;
    logic             close;

    always_comb
    begin
        if (frame_limit < CFG_W'(MIN_FRAME))
            eff_max = CNT_W'(MIN_FRAME);
        else if (32'(frame_limit) > 32'(STORE_BYTES))
            eff_max = CNT_W'(STORE_BYTES);
        else
            eff_max = CNT_W'(frame_limit);
    end

    assign fill_w   = (fill_reg < HDR_CNT) ? HDR_CNT : fill_reg;
    assign fill_inc = fill_w + CNT_W'(1);
    assign pos_inc  = read_pos_reg + CNT_W'(1);
    assign hdr_word = 32'(frame_len_reg) >> {read_pos_reg[1:0], 3'b000};

    always_comb
    begin
        fill_next      = fill_reg;
        frame_len_next = frame_len_reg;
        read_pos_next  = read_pos_reg;
        draining_next  = draining_reg;
        res            = '0;
        res.status     = ST_OK;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        close          = 1'b0;
        if (fire)
        begin
            case (opcode)
                OP_WRITE:
                begin
                    if (draining_reg)
                        res.status = ST_BUSY;
                    else
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_inc;
                        if (fill_inc >= eff_max)
                            close = 1'b1;
                    end
                end
                OP_FLUSH:
                begin
                    if (!draining_reg && fill_reg > HDR_CNT)
                        close = 1'b1;
                end
                OP_READ:
                begin
                    if (draining_reg)
                    begin
                        res.valid = 1'b1;
                        if (read_pos_reg < HDR_CNT)
                            res.data = hdr_word[7:0];
                        else
                        begin
                            res.use_mem = 1'b1;
                            rd_en       = 1'b1;
                        end
                        if (pos_inc >= frame_len_reg)
                        begin
                            res.last       = 1'b1;
                            draining_next  = 1'b0;
                            fill_next      = '0;
                            read_pos_next  = '0;
                            frame_len_next = '0;
                        end
                        else
                            read_pos_next = pos_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (close)
        begin
            frame_len_next = fill_next;
            read_pos_next  = '0;
            draining_next  = 1'b1;
        end
        res.pending = draining_next ? PEND_W'(frame_len_next - read_pos_next) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[fill_w[ADDR_W-1:0]] <= data_in;
        if (rd_en)
            mem_rdata_reg <= mem[read_pos_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            frame_len_reg <= '0;
            read_pos_reg  <= '0;
            draining_reg  <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            frame_len_reg <= frame_len_next;
            read_pos_reg  <= read_pos_next;
            draining_reg  <= draining_next;
        end
    end

    assign mem_rdata = mem_rdata_reg;

endmodule

@@ src/lpfd_rx.sv @@
`timescale 1ns / 1ps
// Receive path: header collection, length check and payload pass-through.
// Depends on lpfd_pkg.
module lpfd_rx
    import lpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_in,
    output res_t       res
);

    logic [23:0] header_reg, header_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] len_reg, len_next;

    logic [31:0] count_inc;
    logic [31:0] full_len;
    logic        in_header;

    assign in_header = (count_reg < 32'(HDR_BYTES));
    assign count_inc = count_reg + 32'd1;
    assign full_len  = {data_in, header_reg};

    always_comb
    begin
        header_next = header_reg;
        count_next  = count_reg;
        len_next    = len_reg;
        res         = '0;
        res.status  = ST_OK;
        if (fire)
        begin
            if (in_header)
            begin
                count_next = count_inc;
                case (count_reg[1:0])
                    2'd0:    header_next = {16'h0000, data_in};
                    2'd1:    header_next = {header_reg[23:16], data_in, header_reg[7:0]};
                    2'd2:    header_next = {data_in, header_reg[15:0]};
                    default:
                    begin
                        len_next = full_len;
                        if (full_len < 32'(HDR_BYTES))
                        begin
                            res.status  = ST_BAD_LEN;
                            count_next  = '0;
                            header_next = '0;
                        end
                        else if (full_len == 32'(HDR_BYTES))
                        begin
                            count_next  = '0;
                            header_next = '0;
                        end
                    end
                endcase
            end
            else
            begin
                res.data   = data_in;
                res.valid  = 1'b1;
                count_next = count_inc;
                if (count_inc >= len_reg)
                begin
                    res.last    = 1'b1;
                    count_next  = '0;
                    header_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            count_reg  <= '0;
            len_reg    <= '0;
        end
        else
        begin
            header_reg <= header_next;
            count_reg  <= count_next;
            len_reg    <= len_next;
        end
    end

endmodule

@@ src/length_prefixed_framer_deframer.sv @@
`timescale 1ns / 1ps
// Top level of the length-prefixed framer/deframer.
// Depends on lpfd_pkg, lpfd_ifs, lpfd_tx and lpfd_rx.
//
// Usage:
//   item   - request channel (valid/ready): opcode and data_in. Opcode 0 writes a
//            payload byte, 1 flushes a short frame, 2 reads one framed byte,
//            3 feeds one received framed byte.
//   result - one result per request: data_out, data_valid, frame_last, status,
//            pending. Result order matches request order.
//   cfg_wr_en / cfg_wr_data - write the frame size limit (header included); write it
//            only while no request is in flight.
// Throughput: one request per cycle, sustained while the result receiver holds ready high.
// Path: a request is registered into the s1 stage, then into the s2 result register;
//   the s2 stage also takes the registered read of the 16 KiB transmit frame buffer.
// Reset: counters clear, no frame drains, receiver waits for a header,
//   the frame size limit returns to 16384. The buffer itself is not cleared.
// Stall: when the result receiver holds ready low, the result register and
//   the stage behind it hold; item.ready drops once both are full.
module length_prefixed_framer_deframer
    import lpfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    lpfd_item_if.sink            item,
    lpfd_result_if.source        result
);

    logic [CFG_W-1:0] max_frame_reg;

    logic             accept;
    op_t              opcode;
    res_t             tx_res;
    res_t             rx_res;
    res_t             s0_res;
    logic [7:0]       mem_rdata;

    logic             s1_valid_reg;
    res_t             s1_res_reg;
    logic             s1_adv;

    logic             s2_valid_reg;
    logic [7:0]       s2_data_reg;
    logic             s2_dvalid_reg;
    logic             s2_last_reg;
    logic [1:0]       s2_status_reg;
    logic [PEND_W-1:0] s2_pending_reg;

    assign opcode     = op_t'(item.opcode);
    assign s1_adv     = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_adv;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_reg <= CFG_RESET;
        else if (cfg_wr_en)
            max_frame_reg <= cfg_wr_data;
    end

    lpfd_tx u_tx (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (accept && (opcode != OP_RECV)),
        .opcode         (opcode),
        .data_in        (item.data_in),
        .frame_limit    (max_frame_reg),
        .res            (tx_res),
        .mem_rdata      (mem_rdata)
    );

    lpfd_rx u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (accept && (opcode == OP_RECV)),
        .data_in (item.data_in),
        .res     (rx_res)
    );

    always_comb
    begin
        s0_res         = (opcode == OP_RECV) ? rx_res : tx_res;
        s0_res.pending = tx_res.pending;
    end

    // hold the stage while the result register is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_res_reg <= s0_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (!s2_valid_reg || result.ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_data_reg    <= s1_res_reg.use_mem ? mem_rdata : s1_res_reg.data;
            s2_dvalid_reg  <= s1_res_reg.valid;
            s2_last_reg    <= s1_res_reg.last;
            s2_status_reg  <= s1_res_reg.status;
            s2_pending_reg <= s1_res_reg.pending;
        end
    end

    assign result.valid      = s2_valid_reg;
    assign result.data_out   = s2_data_reg;
    assign result.data_valid = s2_dvalid_reg;
    assign result.frame_last = s2_last_reg;
    assign result.status     = s2_status_reg;
    assign result.pending    = s2_pending_reg;

endmodule
